[rtl/core/bpt_pkg.sv]
// Package for the bracket pair table builder.
// Codes, result kinds and the controller/datapath command and status structs.
// No dependencies.
package bpt_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned SYMBOL_W   = 8;
    localparam int unsigned POSITION_W = 10;
    localparam int unsigned PARTNER_W  = 11;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned LENGTH_W   = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_A  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_B  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_B = 2'd3;

    localparam logic [CFG_DATA_W-1:0] RST_OPEN_A  = 8'd40;
    localparam logic [CFG_DATA_W-1:0] RST_CLOSE_A = 8'd41;
    localparam logic [CFG_DATA_W-1:0] RST_OPEN_B  = 8'd60;
    localparam logic [CFG_DATA_W-1:0] RST_CLOSE_B = 8'd62;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNBALANCED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BEYOND_LEN = 2'd3;

    localparam logic signed [PARTNER_W-1:0] PARTNER_NONE = '1;

    typedef enum logic [1:0] {
        RES_APPEND = 2'd0,
        RES_FULL   = 2'd1,
        RES_OOB    = 2'd2,
        RES_READ   = 2'd3
    } t_res_kind;

    typedef struct packed {
        logic      load;
        logic      rd_issue;
        logic      simple_append;
        logic      pop_issue;
        logic      pop_wr1;
        logic      pop_wr2;
        logic      res_load;
        t_res_kind res_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic is_read;
        logic is_open;
        logic is_close;
        logic full;
        logic stack_empty;
        logic oob;
    } t_dp_stat;

endpackage

[rtl/core/bpt_if.sv]
// Valid/ready channel interfaces for the bracket pair table builder.
// Depends on bpt_pkg for field widths.
interface bpt_in_if import bpt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic                  first;
    logic [SYMBOL_W-1:0]   symbol;
    logic [POSITION_W-1:0] position;

    modport source (output valid, cmd, first, symbol, position, input ready);
    modport sink   (input valid, cmd, first, symbol, position, output ready);
endinterface

interface bpt_out_if import bpt_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [PARTNER_W-1:0] partner;
    logic [STATUS_W-1:0]         status;
    logic [LENGTH_W-1:0]         length;

    modport source (output valid, partner, status, length, input ready);
    modport sink   (input valid, partner, status, length, output ready);
endinterface

[rtl/core/bpt_ctrl.sv]
// Controller FSM for the bracket pair table builder.
// Sequences item decode, memory accesses and result hand-off; uses bpt_pkg.
module bpt_ctrl import bpt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_CHECK   = 7'b0000010,
        S_RDWAIT  = 7'b0000100,
        S_POPWAIT = 7'b0001000,
        S_POPWR   = 7'b0010000,
        S_FIN     = 7'b0100000,
        S_OUT     = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_kind = RES_APPEND;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.is_read) begin
                    if (i_stat.oob) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_kind = RES_OOB;
                        n_state        = S_OUT;
                    end else begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = S_RDWAIT;
                    end
                end else if (i_stat.full) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_kind = RES_FULL;
                    n_state        = S_OUT;
                end else if (i_stat.is_close && !i_stat.is_open && !i_stat.stack_empty) begin
                    o_cmd.pop_issue = 1'b1;
                    n_state         = S_POPWAIT;
                end else begin
                    o_cmd.simple_append = 1'b1;
                    n_state             = S_FIN;
                end
            end
            S_RDWAIT: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_kind = RES_READ;
                n_state        = S_OUT;
            end
            S_POPWAIT: begin
                o_cmd.pop_wr1 = 1'b1;
                n_state       = S_POPWR;
            end
            S_POPWR: begin
                o_cmd.pop_wr2 = 1'b1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_kind = RES_APPEND;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

[rtl/core/bpt_dp.sv]
// Datapath for the bracket pair table builder: character registers, stack and
// pair memories, length/depth counters and the result register. Uses bpt_pkg.
module bpt_dp import bpt_pkg::*; #(
    parameter int unsigned MAX_LEN = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_cmd,
    input  logic                        i_first,
    input  logic [SYMBOL_W-1:0]         i_symbol,
    input  logic [POSITION_W-1:0]       i_position,
    input  t_dp_cmd                     i_ctl,
    output t_dp_stat                    o_stat,
    output logic signed [PARTNER_W-1:0] o_partner,
    output logic [STATUS_W-1:0]         o_status,
    output logic [LENGTH_W-1:0]         o_length
);

    localparam int unsigned AW = $clog2(MAX_LEN);
    localparam int unsigned LW = $clog2(MAX_LEN + 1);

    logic [CFG_DATA_W-1:0] r_open_a, r_close_a, r_open_b, r_close_b;

    logic                  r_cmd;
    logic [SYMBOL_W-1:0]   r_sym;
    logic [POSITION_W-1:0] r_pos;

    logic [LW-1:0] r_len;
    logic [LW-1:0] r_depth;
    logic          r_flag;

    logic [AW-1:0]          stack_mem [MAX_LEN];
    logic [PARTNER_W-1:0]   pair_mem  [MAX_LEN];
    logic [AW-1:0]          r_stack_rd;
    logic [PARTNER_W-1:0]   r_pair_rd;

    logic                   is_open, is_close;
    logic [AW-1:0]          cur_pos;
    logic [LW-1:0]          depth_m1;
    logic                   pair_we;
    logic [AW-1:0]          pair_waddr;
    logic [PARTNER_W-1:0]   pair_wdata;

    logic signed [PARTNER_W-1:0] r_res_partner;
    logic [STATUS_W-1:0]         r_res_status;
    logic [LENGTH_W-1:0]         r_res_length;

    assign is_open  = (r_sym == r_open_a)  || (r_sym == r_open_b);
    assign is_close = (r_sym == r_close_a) || (r_sym == r_close_b);
    assign cur_pos  = r_len[AW-1:0];
    assign depth_m1 = r_depth - LW'(1);

    assign o_stat.is_read     = (r_cmd == CMD_READ);
    assign o_stat.is_open     = is_open;
    assign o_stat.is_close    = is_close;
    assign o_stat.full        = (r_len == LW'(MAX_LEN));
    assign o_stat.stack_empty = (r_depth == '0);
    assign o_stat.oob         = (32'(r_pos) >= 32'(r_len)) || (32'(r_pos) >= 32'(MAX_LEN));

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_a  <= RST_OPEN_A;
            r_close_a <= RST_CLOSE_A;
            r_open_b  <= RST_OPEN_B;
            r_close_b <= RST_CLOSE_B;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OPEN_A:  r_open_a  <= i_cfg_data;
                CFG_CLOSE_A: r_close_a <= i_cfg_data;
                CFG_OPEN_B:  r_open_b  <= i_cfg_data;
                CFG_CLOSE_B: r_close_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_sym <= i_symbol;
            r_pos <= i_position;
        end
    end

    // structure state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_depth <= '0;
            r_flag  <= 1'b0;
        end else begin
            if (i_ctl.load && (i_cmd == CMD_APPEND) && i_first) begin
                r_len   <= '0;
                r_depth <= '0;
                r_flag  <= 1'b0;
            end
            if (i_ctl.simple_append) begin
                r_len <= r_len + LW'(1);
                if (is_open && !is_close) begin
                    r_depth <= r_depth + LW'(1);
                end
                if (is_close && !is_open && (r_depth == '0)) begin
                    r_flag <= 1'b1;
                end
            end
            if (i_ctl.pop_issue) begin
                r_depth <= depth_m1;
            end
            if (i_ctl.pop_wr2) begin
                r_len <= r_len + LW'(1);
            end
        end
    end

    // open-position stack
    always_ff @(posedge i_clk) begin
        if (i_ctl.simple_append && is_open && !is_close) begin
            stack_mem[r_depth[AW-1:0]] <= cur_pos;
        end
        if (i_ctl.pop_issue) begin
            r_stack_rd <= stack_mem[depth_m1[AW-1:0]];
        end
    end

    // pair table
    assign pair_we    = i_ctl.simple_append || i_ctl.pop_wr1 || i_ctl.pop_wr2;
    assign pair_waddr = i_ctl.pop_wr2 ? r_stack_rd : cur_pos;

    always_comb begin
        if (i_ctl.pop_wr2) begin
            pair_wdata = PARTNER_W'(cur_pos);
        end else if (i_ctl.pop_wr1) begin
            pair_wdata = PARTNER_W'(r_stack_rd);
        end else if (is_open && is_close) begin
            pair_wdata = PARTNER_W'(cur_pos);
        end else begin
            pair_wdata = PARTNER_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pair_we) begin
            pair_mem[pair_waddr] <= pair_wdata;
        end
        if (i_ctl.rd_issue) begin
            r_pair_rd <= pair_mem[AW'(r_pos)];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.res_load) begin
            r_res_length <= LENGTH_W'(r_len);
            case (i_ctl.res_kind)
                RES_FULL: begin
                    r_res_partner <= PARTNER_NONE;
                    r_res_status  <= STATUS_TOO_LONG;
                end
                RES_OOB: begin
                    r_res_partner <= PARTNER_NONE;
                    r_res_status  <= STATUS_BEYOND_LEN;
                end
                RES_READ: begin
                    r_res_partner <= r_pair_rd;
                    r_res_status  <= r_flag ? STATUS_UNBALANCED : STATUS_OK;
                end
                default: begin
                    r_res_partner <= PARTNER_NONE;
                    r_res_status  <= r_flag ? STATUS_UNBALANCED : STATUS_OK;
                end
            endcase
        end
    end

    assign o_partner = r_res_partner;
    assign o_status  = r_res_status;
    assign o_length  = r_res_length;

endmodule

[rtl/core/bracket_pair_table_builder.sv]
// Bracket pair table builder: one item at a time. A read does a pair-table
// read; an open, dot or unbalanced close does one write; a pop a stack read,
// then two pair-table writes on the single write port; a full or out-of-range
// item answers without a memory access. The next item is taken in the cycle
// after the result is taken. Synchronous active-low reset clears the FSM,
// length, depth, unbalanced flag and restores default bracket codes; memories
// are not cleared (every pair entry is written before it can be read).
module bracket_pair_table_builder import bpt_pkg::*; #(
    parameter int unsigned MAX_LEN = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bpt_in_if.sink                i_in,
    bpt_out_if.source             o_out
);

    t_dp_cmd  ctl;
    t_dp_stat stat;

    bpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (ctl)
    );

    bpt_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (i_in.cmd),
        .i_first    (i_in.first),
        .i_symbol   (i_in.symbol),
        .i_position (i_in.position),
        .i_ctl      (ctl),
        .o_stat     (stat),
        .o_partner  (o_out.partner),
        .o_status   (o_out.status),
        .o_length   (o_out.length)
    );

endmodule

[rtl/core/bpt_checker.sv]
// Port-level checks for the bracket pair table builder, bound to the top level.
// Depends on bpt_pkg.
module bpt_checker import bpt_pkg::*; #(
    parameter int unsigned MAX_LEN = 1024
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic signed [PARTNER_W-1:0] i_partner,
    input logic [STATUS_W-1:0]         i_status,
    input logic [LENGTH_W-1:0]         i_length
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_partner)
            && $stable(i_status) && $stable(i_length)))
        else $error("result item dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("new item accepted while one is in flight");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == STATUS_TOO_LONG)) |-> (i_length == LENGTH_W'(MAX_LEN)))
        else $error("too-long status with length below maximum");

    a_oob_partner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == STATUS_BEYOND_LEN)) |-> (i_partner == PARTNER_NONE))
        else $error("out-of-range read returned a partner");

    a_partner_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_partner != PARTNER_NONE))
            |-> ((i_status == STATUS_OK) || (i_status == STATUS_UNBALANCED)))
        else $error("partner returned with error status");

endmodule

bind bracket_pair_table_builder bpt_checker #(.MAX_LEN(MAX_LEN)) u_bpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_partner   (o_out.partner),
    .i_status    (o_out.status),
    .i_length    (o_out.length)
);

[tb/sv/tb_bracket_pair_table_builder.sv]
// Testbench for bracket_pair_table_builder: directed table, then random structures.
// Typed rows or a pair-table predictor give each expected result; uses bpt_pkg, bpt_if.
// Valid/ready stalls, a long receiver hold-off and bracket code changes between phases.
module tb_bracket_pair_table_builder;
    import bpt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_LEN     = 1024;
    localparam int          STALL_LIMIT = 2000;
    localparam logic [7:0]  DOT         = 8'd46;

    typedef struct packed {
        logic                  cmd;
        logic                  first;
        logic [SYMBOL_W-1:0]   symbol;
        logic [POSITION_W-1:0] position;
    } char_item_t;

    typedef struct packed {
        logic signed [PARTNER_W-1:0] partner;
        logic [STATUS_W-1:0]         status;
        logic [LENGTH_W-1:0]         length;
    } pair_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    // ROW_CFG rows write item.symbol to register cfg_idx
    typedef struct {
        row_kind_e              kind;
        char_item_t             item;
        int                     reps;
        bit                     typed;
        pair_result_t           want;
        logic [CFG_IDX_W-1:0]   cfg_idx;
    } dir_row_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bpt_in_if  in_ch();
    bpt_out_if out_ch();

    bracket_pair_table_builder #(.MAX_LEN(MAX_LEN)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // predictor state
    logic [CFG_DATA_W-1:0]       bracket_codes [4];
    logic [POSITION_W-1:0]       open_positions [MAX_LEN];
    logic signed [PARTNER_W-1:0] partner_table [MAX_LEN];
    logic [LENGTH_W-1:0]         open_depth;
    logic [LENGTH_W-1:0]         struct_len;
    logic                        unbalanced;

    pair_result_t partner_answers_q [$];
    int           fail_count = 0;
    bit           in_idle_on = 1'b0;
    bit           out_idle_on = 1'b0;
    bit           long_hold_req = 1'b0;

    dir_row_t directed_rows [31] = '{
        '{ROW_ITEM, '{CMD_READ, 1'b0, DOT, 10'd0}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_BEYOND_LEN, 11'd0}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_READ, 1'b1, 8'hFF, 10'd1023}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_BEYOND_LEN, 11'd0}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_APPEND, 1'b1, RST_CLOSE_A, 10'd0}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_UNBALANCED, 11'd1}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_APPEND, 1'b0, DOT, 10'd0}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_UNBALANCED, 11'd2}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_READ, 1'b0, DOT, 10'd0}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_UNBALANCED, 11'd2}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_APPEND, 1'b1, RST_OPEN_A, 10'd0}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_OK, 11'd1}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_APPEND, 1'b0, RST_OPEN_B, 10'd0}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_OK, 11'd2}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_APPEND, 1'b0, 8'hFF, 10'h3FF}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_OK, 11'd3}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_APPEND, 1'b0, RST_CLOSE_A, 10'd0}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_OK, 11'd4}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_APPEND, 1'b0, RST_CLOSE_B, 10'd0}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_OK, 11'd5}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_READ, 1'b0, DOT, 10'd0}, 1, 1'b1,
          '{11'sd4, STATUS_OK, 11'd5}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_READ, 1'b0, DOT, 10'd2}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_OK, 11'd5}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_READ, 1'b0, DOT, 10'd5}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_BEYOND_LEN, 11'd5}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_APPEND, 1'b0, 8'h00, 10'd0}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_OK, 11'd6}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_READ, 1'b0, DOT, 10'h3FF}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_BEYOND_LEN, 11'd6}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_APPEND, 1'b0, RST_CLOSE_B, 10'd0}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_UNBALANCED, 11'd7}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_READ, 1'b0, DOT, 10'd1}, 1, 1'b1,
          '{11'sd3, STATUS_UNBALANCED, 11'd7}, CFG_OPEN_A},
        // fill to the length limit: 512 opens, 512 closes
        '{ROW_ITEM, '{CMD_APPEND, 1'b1, RST_OPEN_A, 10'd0}, 1, 1'b0, '0, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_APPEND, 1'b0, RST_OPEN_A, 10'd0}, 511, 1'b0, '0, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_APPEND, 1'b0, RST_CLOSE_A, 10'd0}, 512, 1'b0, '0, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_APPEND, 1'b0, DOT, 10'd0}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_TOO_LONG, 11'd1024}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_APPEND, 1'b0, RST_OPEN_A, 10'd0}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_TOO_LONG, 11'd1024}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_READ, 1'b0, DOT, 10'd1023}, 1, 1'b1,
          '{11'sd0, STATUS_OK, 11'd1024}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_READ, 1'b0, DOT, 10'd0}, 1, 1'b1,
          '{11'sd1023, STATUS_OK, 11'd1024}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_READ, 1'b0, DOT, 10'd511}, 1, 1'b0, '0, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_APPEND, 1'b1, DOT, 10'd0}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_OK, 11'd1}, CFG_OPEN_A},
        // same code opens and closes: position pairs with itself
        '{ROW_CFG, '{CMD_APPEND, 1'b0, RST_OPEN_A, 10'd0}, 1, 1'b0, '0, CFG_CLOSE_A},
        '{ROW_ITEM, '{CMD_APPEND, 1'b1, RST_OPEN_A, 10'd0}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_OK, 11'd1}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_READ, 1'b0, DOT, 10'd0}, 1, 1'b1,
          '{11'sd0, STATUS_OK, 11'd1}, CFG_OPEN_A},
        '{ROW_ITEM, '{CMD_APPEND, 1'b0, RST_CLOSE_A, 10'd0}, 1, 1'b1,
          '{PARTNER_NONE, STATUS_OK, 11'd2}, CFG_OPEN_A},
        '{ROW_CFG, '{CMD_APPEND, 1'b0, RST_CLOSE_A, 10'd0}, 1, 1'b0, '0, CFG_CLOSE_A}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic pair_result_t pair_table_step(input char_item_t it);
        pair_result_t          r;
        logic [POSITION_W-1:0] pos;
        logic [POSITION_W-1:0] mate;
        r.partner = PARTNER_NONE;
        if (it.cmd == CMD_APPEND) begin
            if (it.first) begin
                open_depth = '0;
                struct_len = '0;
                unbalanced = 1'b0;
            end
            if (struct_len >= LENGTH_W'(MAX_LEN)) begin
                r.status = STATUS_TOO_LONG;
            end else begin
                pos = struct_len[POSITION_W-1:0];
                partner_table[pos] = PARTNER_NONE;
                if (it.symbol == bracket_codes[CFG_OPEN_A] ||
                    it.symbol == bracket_codes[CFG_OPEN_B]) begin
                    if (open_depth < LENGTH_W'(MAX_LEN)) begin
                        open_positions[open_depth[POSITION_W-1:0]] = pos;
                        open_depth = open_depth + LENGTH_W'(1);
                    end
                end
                if (it.symbol == bracket_codes[CFG_CLOSE_A] ||
                    it.symbol == bracket_codes[CFG_CLOSE_B]) begin
                    if (open_depth == '0) begin
                        unbalanced = 1'b1;
                    end else begin
                        open_depth = open_depth - LENGTH_W'(1);
                        mate = open_positions[open_depth[POSITION_W-1:0]];
                        partner_table[mate] = {1'b0, pos};
                        partner_table[pos]  = {1'b0, mate};
                    end
                end
                struct_len = struct_len + LENGTH_W'(1);
                r.status = unbalanced ? STATUS_UNBALANCED : STATUS_OK;
            end
        end else if (LENGTH_W'(it.position) >= struct_len) begin
            r.status = STATUS_BEYOND_LEN;
        end else begin
            r.partner = partner_table[it.position];
            r.status  = unbalanced ? STATUS_UNBALANCED : STATUS_OK;
        end
        r.length = struct_len;
        return r;
    endfunction

    task automatic send_item(input char_item_t it, input bit typed, input pair_result_t want);
        pair_result_t predicted;
        if (in_idle_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.cmd      <= it.cmd;
        in_ch.first    <= it.first;
        in_ch.symbol   <= it.symbol;
        in_ch.position <= it.position;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        predicted = pair_table_step(it);
        partner_answers_q.push_back(typed ? want : predicted);
    endtask

    task automatic wait_results_done();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (partner_answers_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_code(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
        wait_results_done();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        bracket_codes[idx] = val;
        @(posedge i_clk);
    endtask

    task automatic write_all_codes(input logic [7:0] oa, input logic [7:0] ca,
                                   input logic [7:0] ob, input logic [7:0] cb);
        write_code(CFG_OPEN_A, oa);
        write_code(CFG_CLOSE_A, ca);
        write_code(CFG_OPEN_B, ob);
        write_code(CFG_CLOSE_B, cb);
    endtask

    function automatic char_item_t random_read(input int filled);
        char_item_t it;
        it.cmd    = CMD_READ;
        it.first  = 1'($urandom_range(0, 1));
        it.symbol = 8'($urandom_range(0, 255));
        if (filled > 0 && $urandom_range(0, 4) != 0)
            it.position = 10'($urandom_range(0, filled - 1));
        else
            it.position = 10'($urandom_range(0, 1023));
        return it;
    endfunction

    // mostly nested structures; some broken ones close on an empty stack
    task automatic run_random(input int n_items, input bit pause_mid);
        int         sent;
        int         slen;
        int         depth;
        int         k;
        int         r;
        bit         broken;
        bit         paused;
        char_item_t it;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            slen   = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                 : $urandom_range(1, 40);
            broken = ($urandom_range(0, 7) == 0);
            depth  = 0;
            for (k = 0; k < slen; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_item(random_read(k), 1'b0, '0);
                    sent++;
                end
                it.cmd      = CMD_APPEND;
                it.first    = (k == 0);
                it.position = 10'($urandom_range(0, 1023));
                r = $urandom_range(0, 99);
                if (r < 40 || (r < 75 && depth == 0 && !broken))
                    it.symbol = $urandom_range(0, 1) ? bracket_codes[CFG_OPEN_A]
                                                     : bracket_codes[CFG_OPEN_B];
                else if (r < 75)
                    it.symbol = $urandom_range(0, 1) ? bracket_codes[CFG_CLOSE_A]
                                                     : bracket_codes[CFG_CLOSE_B];
                else if (r < 92)
                    it.symbol = DOT;
                else
                    it.symbol = 8'($urandom_range(0, 255));
                if (it.symbol == bracket_codes[CFG_OPEN_A] ||
                    it.symbol == bracket_codes[CFG_OPEN_B])
                    depth++;
                if ((it.symbol == bracket_codes[CFG_CLOSE_A] ||
                     it.symbol == bracket_codes[CFG_CLOSE_B]) && depth > 0)
                    depth--;
                send_item(it, 1'b0, '0);
                sent++;
            end
            repeat ($urandom_range(1, 6)) begin
                send_item(random_read(slen), 1'b0, '0);
                sent++;
            end
            if (pause_mid && !paused && sent >= n_items / 2) begin
                wait_results_done();
                paused = 1'b1;
            end
        end
    endtask

    initial begin : stimulus
        int k;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_OPEN_A;
        i_cfg_data     <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.cmd      <= CMD_APPEND;
        in_ch.first    <= 1'b0;
        in_ch.symbol   <= '0;
        in_ch.position <= '0;
        bracket_codes[CFG_OPEN_A]  = RST_OPEN_A;
        bracket_codes[CFG_CLOSE_A] = RST_CLOSE_A;
        bracket_codes[CFG_OPEN_B]  = RST_OPEN_B;
        bracket_codes[CFG_CLOSE_B] = RST_CLOSE_B;
        open_depth = '0;
        struct_len = '0;
        unbalanced = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_code(directed_rows[i].cfg_idx, directed_rows[i].item.symbol);
            end else begin
                for (k = 0; k < directed_rows[i].reps; k++)
                    send_item(directed_rows[i].item, directed_rows[i].typed,
                              directed_rows[i].want);
            end
        end

        write_all_codes(8'd0, 8'd255, 8'd0, 8'd255);
        long_hold_req = 1'b1;
        run_random(165, 1'b0);

        write_all_codes(8'd255, 8'd0, 8'd255, 8'd0);
        run_random(165, 1'b1);

        k = $urandom_range(0, 255);
        write_all_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'(k), 8'(k));
        run_random(165, 1'b0);

        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        write_all_codes(RST_OPEN_A, RST_CLOSE_A, RST_OPEN_B, RST_CLOSE_B);
        run_random(165, 1'b0);

        wait_results_done();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && partner_answers_q.size() == 0)
            $display("bracket_pair_table_builder verification clean");
        else
            $display("bracket_pair_table_builder verification failed");
        $finish;
    end

    initial begin : result_checker
        pair_result_t want;
        int           hold;
        hold = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (partner_answers_q.size() == 0) begin
                    $error("unexpected item: partner %0d status %0d length %0d",
                           out_ch.partner, out_ch.status, out_ch.length);
                    fail_count++;
                end else begin
                    want = partner_answers_q.pop_front();
                    if (out_ch.partner !== want.partner) begin
                        $error("partner: expected %0d, got %0d", want.partner, out_ch.partner);
                        fail_count++;
                    end
                    if (out_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_ch.status);
                        fail_count++;
                    end
                    if (out_ch.length !== want.length) begin
                        $error("length: expected %0d, got %0d", want.length, out_ch.length);
                        fail_count++;
                    end
                end
            end
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (hold > 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = 299;
                out_ch.ready <= 1'b0;
            end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(0, 14);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("bracket_pair_table_builder verification failed");
                $finish;
            end
        end
    end

endmodule

[filelist.f]
rtl/core/bpt_pkg.sv
rtl/core/bpt_if.sv
rtl/core/bpt_ctrl.sv
rtl/core/bpt_dp.sv
rtl/core/bracket_pair_table_builder.sv
rtl/core/bpt_checker.sv
tb/sv/tb_bracket_pair_table_builder.sv
